/* rtl/wmt_pkg.sv */
// Shared types and constants for the magnitude statistics block.
package wmt_pkg;

  localparam int unsigned SCALE_W = 24;
  localparam int unsigned OFS_W   = 24;
  localparam int unsigned SIGMA_W = 16;
  localparam int unsigned VAL_W   = 24;
  localparam int unsigned OCNT_W  = 16;
  localparam int unsigned ACC_W   = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE  = 3'd0,
    CFG_OFS_X  = 3'd1,
    CFG_OFS_Y  = 3'd2,
    CFG_OFS_Z  = 3'd3,
    CFG_SIGMA  = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AXMUL,
    ST_AXFIN,
    ST_MSQRT,
    ST_MDIV,
    ST_MEAN,
    ST_EMUL,
    ST_ACC,
    ST_VDIV,
    ST_SSQRT,
    ST_TMUL,
    ST_TFIN,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic                     kind;
    logic signed [ACC_W-1:0]  accel_x;
    logic signed [ACC_W-1:0]  accel_y;
    logic signed [ACC_W-1:0]  accel_z;
  } in_item_t;

  typedef struct packed {
    logic [VAL_W-1:0]  magnitude;
    logic [VAL_W-1:0]  mean;
    logic [VAL_W-1:0]  std_dev;
    logic [VAL_W-1:0]  threshold;
    logic [OCNT_W-1:0] sample_count;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
  } cfg_item_t;

endpackage

/* rtl/wmt_if.sv */
// Valid/ready channel interfaces for items and configuration writes.
interface wmt_in_if;
  logic              valid;
  logic              ready;
  wmt_pkg::in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface wmt_out_if;
  logic               valid;
  logic               ready;
  wmt_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface wmt_cfg_if;
  logic               valid;
  logic               ready;
  wmt_pkg::cfg_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/welford_magnitude_threshold.sv */
// Top level: calibrated magnitude and running Welford statistics, bit-serial datapath.
// Per sample: axis multiply and square, magnitude root, mean divide, variance update,
// variance divide, std-dev root and threshold multiply. The first sample of a period stops
// after the variance update, a saturated count skips the statistics, and a clear item goes
// straight to the output state. One item at a time; the next input can be accepted the
// cycle after the result is taken.
// Reset: asynchronous, active low; statistics zero, registers at their defaults.
module welford_magnitude_threshold #(
  parameter int unsigned COUNT_BITS = 16,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  wmt_in_if.sink     in_i,
  wmt_out_if.source  out_o,
  wmt_cfg_if.sink    cfg_i
);

  localparam int unsigned PROD_W = 41;   // 16x24 signed product
  localparam int unsigned SHR    = 16 - FRAC_BITS;
  localparam int unsigned SQ_W   = 50;   // up to 3 * 2^48
  localparam int unsigned SCNT_W = 7;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  // configuration
  logic [wmt_pkg::SCALE_W-1:0]        scale_q;
  logic signed [wmt_pkg::OFS_W-1:0]   ofs_q [3];
  logic [wmt_pkg::SIGMA_W-1:0]        sigma_q;

  // statistics
  logic [31:0]            mean_q, mean_d;
  logic [63:0]            ssum_q, ssum_d;
  logic [COUNT_BITS-1:0]  cnt_q, cnt_d;
  logic [23:0]            thr_q, thr_d;

  wmt_pkg::state_e state_q, state_d;
  logic [SCNT_W-1:0] step_q, step_d;
  logic [1:0]        axis_q, axis_d;
  wmt_pkg::in_item_t item_q, item_d;

  // serial multiply: acc += mcand when multiplier lsb set, mcand <<= 1
  logic [63:0] mc_q, mc_d;     // multiplicand (shifting)
  logic [31:0] mp_q, mp_d;     // multiplier (shifting)
  logic [63:0] acc_q, acc_d;   // product accumulator
  logic        neg_q, neg_d;

  // shared sqrt / divide registers
  logic [63:0] rem_q, rem_d;   // remainder / radicand
  logic [63:0] quo_q, quo_d;   // quotient / root
  logic [63:0] num_q, num_d;   // dividend bits still to shift
  logic [31:0] dvs_q, dvs_d;

  logic [SQ_W-1:0]   sq_q, sq_d;      // sum of squares
  logic [23:0]       mag_q, mag_d;
  logic signed [33:0] delta_q, delta_d;
  logic [23:0]       sd_q, sd_d;

  wmt_pkg::out_item_t res_q, res_d;
  logic               ovld_q, ovld_d;

  // config write
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= 24'd65536;
      ofs_q[0] <= '0;
      ofs_q[1] <= '0;
      ofs_q[2] <= '0;
      sigma_q <= 16'd256;
    end else if (cfg_i.valid) begin
      case (cfg_i.payload.index)
        wmt_pkg::CFG_SCALE: scale_q <= cfg_i.payload.data;
        wmt_pkg::CFG_OFS_X: ofs_q[0] <= cfg_i.payload.data;
        wmt_pkg::CFG_OFS_Y: ofs_q[1] <= cfg_i.payload.data;
        wmt_pkg::CFG_OFS_Z: ofs_q[2] <= cfg_i.payload.data;
        wmt_pkg::CFG_SIGMA: sigma_q <= cfg_i.payload.data[wmt_pkg::SIGMA_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wmt_pkg::ST_IDLE;
      mean_q <= '0;
      ssum_q <= '0;
      cnt_q <= '0;
      thr_q <= '0;
      ovld_q <= 1'b0;
      step_q <= '0;
      axis_q <= '0;
    end else begin
      state_q <= state_d;
      mean_q <= mean_d;
      ssum_q <= ssum_d;
      cnt_q <= cnt_d;
      thr_q <= thr_d;
      ovld_q <= ovld_d;
      step_q <= step_d;
      axis_q <= axis_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    mc_q <= mc_d;
    mp_q <= mp_d;
    acc_q <= acc_d;
    neg_q <= neg_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    num_q <= num_d;
    dvs_q <= dvs_d;
    sq_q <= sq_d;
    mag_q <= mag_d;
    delta_q <= delta_d;
    sd_q <= sd_d;
    res_q <= res_d;
  end

  assign in_i.ready    = (state_q == wmt_pkg::ST_IDLE) && !ovld_q;
  assign out_o.valid   = ovld_q;
  assign out_o.payload = res_q;

  // combinational helpers
  logic signed [PROD_W-1:0] prod_s;
  logic signed [PROD_W:0]   cal_s;
  logic [PROD_W:0]          cal_abs;
  logic [24:0]              cal_clamp;
  logic [63:0]              sq_try;
  logic [64:0]              div_try;
  logic [63:0]              cnt_ext;
  logic [64:0]              sum_chk;
  logic [63:0]              term;
  logic signed [33:0]       e_s;
  logic [33:0]              e_abs;
  logic [33:0]              d_abs;

  always_comb begin
    prod_s  = neg_q ? -$signed(acc_q[PROD_W-1:0]) : $signed(acc_q[PROD_W-1:0]);
    cal_s   = (PROD_W+1)'(prod_s >>> SHR) + (PROD_W+1)'(ofs_q[axis_q]);
    cal_abs = cal_s[PROD_W] ? (PROD_W+1)'(-cal_s) : cal_s;
    cal_clamp = (cal_abs > (PROD_W+1)'(25'h1000000)) ? 25'h1000000 : cal_abs[24:0];
    sq_try  = rem_q - (quo_q | num_q);
    div_try = {rem_q, num_q[63]} - {33'd0, dvs_q};
    cnt_ext = 64'(cnt_q);
    e_s     = $signed({2'b00, mag_q, 8'd0}) - $signed({2'b00, mean_q});
    e_abs   = e_s[33] ? 34'(-e_s) : e_s;
    d_abs   = delta_q[33] ? 34'(-delta_q) : delta_q;
    term    = acc_q >> 16;
    sum_chk = {1'b0, ssum_q} + {1'b0, term};
  end

  always_comb begin
    state_d = state_q;
    step_d = step_q;
    axis_d = axis_q;
    item_d = item_q;
    mc_d = mc_q;
    mp_d = mp_q;
    acc_d = acc_q;
    neg_d = neg_q;
    rem_d = rem_q;
    quo_d = quo_q;
    num_d = num_q;
    dvs_d = dvs_q;
    sq_d = sq_q;
    mag_d = mag_q;
    delta_d = delta_q;
    sd_d = sd_q;
    mean_d = mean_q;
    ssum_d = ssum_q;
    cnt_d = cnt_q;
    thr_d = thr_q;
    res_d = res_q;
    ovld_d = ovld_q;

    if (ovld_q && out_o.ready) ovld_d = 1'b0;

    case (state_q)
      wmt_pkg::ST_IDLE: begin
        if (in_i.valid && in_i.ready) begin
          item_d = in_i.payload;
          if (in_i.payload.kind) begin
            mean_d = '0;
            ssum_d = '0;
            cnt_d = '0;
            mag_d = '0;
            sd_d = '0;
            state_d = wmt_pkg::ST_OUT;
          end else begin
            axis_d = 2'd0;
            sq_d = '0;
            state_d = wmt_pkg::ST_AXMUL;
            neg_d = in_i.payload.accel_x[15];
            mc_d = 64'(scale_q);
            mp_d = {16'd0, (in_i.payload.accel_x[15] ? 16'(-in_i.payload.accel_x)
                                                     : in_i.payload.accel_x)};
            acc_d = '0;
            step_d = '0;
          end
        end
      end
      // |raw| * scale, one multiplier bit per cycle
      wmt_pkg::ST_AXMUL: begin
        if (mp_q[0]) acc_d = acc_q + mc_q;
        mc_d = mc_q << 1;
        mp_d = mp_q >> 1;
        step_d = step_q + 1'b1;
        if (step_q == SCNT_W'(16)) state_d = wmt_pkg::ST_AXFIN;
      end
      // square the calibrated axis serially, then move to next axis, or to the root after the last
      wmt_pkg::ST_AXFIN: begin
        if (step_q == SCNT_W'(17)) begin
          mc_d = 64'(cal_clamp);
          mp_d = 32'(cal_clamp);
          acc_d = '0;
          step_d = step_q + 1'b1;
        end else begin
          if (mp_q[0]) acc_d = acc_q + mc_q;
          mc_d = mc_q << 1;
          mp_d = mp_q >> 1;
          step_d = step_q + 1'b1;
          if (step_q == SCNT_W'(44)) begin
            sq_d = sq_q + SQ_W'(acc_d);
            step_d = '0;
            if (axis_q == 2'd2) begin
              state_d = wmt_pkg::ST_MSQRT;
              rem_d = 64'(sq_q + SQ_W'(acc_d));
              quo_d = '0;
              num_d = 64'd1 << 62;
            end else begin
              axis_d = axis_q + 1'b1;
              case (axis_q)
                2'd0:    begin
                  neg_d = item_q.accel_y[15];
                  mp_d = {16'd0, (item_q.accel_y[15] ? 16'(-item_q.accel_y)
                                                     : item_q.accel_y)};
                end
                default: begin
                  neg_d = item_q.accel_z[15];
                  mp_d = {16'd0, (item_q.accel_z[15] ? 16'(-item_q.accel_z)
                                                     : item_q.accel_z)};
                end
              endcase
              mc_d = 64'(scale_q);
              acc_d = '0;
              state_d = wmt_pkg::ST_AXMUL;
            end
          end
        end
      end
      // bit-pair square root: num holds the trial bit
      wmt_pkg::ST_MSQRT, wmt_pkg::ST_SSQRT: begin
        if (rem_q >= (quo_q | num_q)) begin
          rem_d = sq_try;
          quo_d = (quo_q >> 1) | num_q;
        end else begin
          quo_d = quo_q >> 1;
        end
        num_d = num_q >> 2;
        if (num_q[0]) begin
          if (state_q == wmt_pkg::ST_MSQRT) begin
            mag_d = (quo_d > 64'hFFFFFF) ? 24'hFFFFFF : quo_d[23:0];
            if (cnt_q != CNT_MAX) begin
              cnt_d = cnt_q + 1'b1;
              delta_d = $signed({2'b00, mag_d, 8'd0}) - $signed({2'b00, mean_q});
              // divide |delta| by new count
              rem_d = '0;
              quo_d = '0;
              num_d = {30'd0, (delta_d[33] ? 34'(-delta_d) : delta_d)} << 30;
              dvs_d = 32'(cnt_q + 1'b1);
              step_d = '0;
              state_d = wmt_pkg::ST_MDIV;
            end else begin
              state_d = wmt_pkg::ST_TFIN;
              sd_d = sd_q;
            end
          end else begin
            sd_d = (quo_d > 64'hFFFFFF) ? 24'hFFFFFF : quo_d[23:0];
            mc_d = 64'(sigma_q);
            mp_d = 32'(sd_d);
            acc_d = '0;
            step_d = '0;
            state_d = wmt_pkg::ST_TMUL;
          end
        end
      end
      // restoring divide, 34 dividend bits
      wmt_pkg::ST_MDIV: begin
        if (!div_try[64]) begin
          rem_d = div_try[63:0];
          quo_d = {quo_q[62:0], 1'b1};
        end else begin
          rem_d = {rem_q[62:0], num_q[63]};
          quo_d = {quo_q[62:0], 1'b0};
        end
        num_d = num_q << 1;
        step_d = step_q + 1'b1;
        if (step_q == SCNT_W'(33)) state_d = wmt_pkg::ST_MEAN;
      end
      wmt_pkg::ST_MEAN: begin
        mean_d = delta_q[33] ? 32'(mean_q - quo_q[31:0]) : 32'(mean_q + quo_q[31:0]);
        state_d = wmt_pkg::ST_EMUL;
        mc_d = 64'(d_abs);
        acc_d = '0;
        step_d = '0;
      end
      wmt_pkg::ST_EMUL: begin
        if (step_q == '0) begin
          mp_d = e_abs[31:0];
          mc_d = {30'd0, d_abs} | {63'd0, 1'b0};
          acc_d = (e_abs[33:32] != 2'b00) ? 64'(d_abs) << 32 : '0;
          if (e_abs[33]) acc_d = acc_d + (64'(d_abs) << 33) - (64'(d_abs) << 32)
                                 + (e_abs[32] ? 64'(d_abs) << 32 : 64'd0)
                                 - (64'(d_abs) << 32);
          step_d = 7'd1;
        end else begin
          if (mp_q[0]) acc_d = acc_q + mc_q;
          mc_d = mc_q << 1;
          mp_d = mp_q >> 1;
          step_d = step_q + 1'b1;
          if (step_q == SCNT_W'(32)) state_d = wmt_pkg::ST_ACC;
        end
      end
      wmt_pkg::ST_ACC: begin
        ssum_d = sum_chk[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum_chk[63:0];
        if (cnt_q > COUNT_BITS'(1)) begin
          rem_d = '0;
          quo_d = '0;
          num_d = sum_chk[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum_chk[63:0];
          dvs_d = 32'(cnt_q - 1'b1);
          step_d = '0;
          state_d = wmt_pkg::ST_VDIV;
        end else begin
          sd_d = '0;
          state_d = wmt_pkg::ST_OUT;
        end
      end
      wmt_pkg::ST_VDIV: begin
        if (!div_try[64]) begin
          rem_d = div_try[63:0];
          quo_d = {quo_q[62:0], 1'b1};
        end else begin
          rem_d = {rem_q[62:0], num_q[63]};
          quo_d = {quo_q[62:0], 1'b0};
        end
        num_d = num_q << 1;
        step_d = step_q + 1'b1;
        if (step_q == SCNT_W'(63)) begin
          rem_d = quo_d;
          quo_d = '0;
          num_d = 64'd1 << 62;
          state_d = wmt_pkg::ST_SSQRT;
        end
      end
      wmt_pkg::ST_TMUL: begin
        if (mp_q[0]) acc_d = acc_q + mc_q;
        mc_d = mc_q << 1;
        mp_d = mp_q >> 1;
        step_d = step_q + 1'b1;
        if (step_q == SCNT_W'(23)) begin
          state_d = wmt_pkg::ST_OUT;
          thr_d = ({9'd0, mean_q[31:8]} + {1'b0, acc_d[39:8]} > 33'hFFFFFF) ?
                  24'hFFFFFF : 24'({9'd0, mean_q[31:8]} + {1'b0, acc_d[39:8]});
        end
      end
      // frozen statistics: std_dev and threshold stay as they stand
      wmt_pkg::ST_TFIN: begin
        state_d = wmt_pkg::ST_OUT;
      end
      wmt_pkg::ST_OUT: begin
        if (!ovld_q) begin
          res_d.magnitude = mag_q;
          res_d.mean = mean_q[31:8];
          res_d.std_dev = sd_q;
          res_d.threshold = thr_q;
          res_d.sample_count = (64'(cnt_q) > 64'hFFFF) ? 16'hFFFF : cnt_ext[15:0];
          ovld_d = 1'b1;
          state_d = wmt_pkg::ST_IDLE;
        end
      end
      default: state_d = wmt_pkg::ST_IDLE;
    endcase
  end

endmodule
